### design/lcdseq_pkg.sv
package lcdseq_pkg;

	// step counter width, covers 41 goto writes and the largest shift limit
	localparam int STEP_W = 6;

	localparam logic [3:0] FUNC_INIT     = 4'd0;
	localparam logic [3:0] FUNC_CHAR     = 4'd1;
	localparam logic [3:0] FUNC_CURSOR   = 4'd2;
	localparam logic [3:0] FUNC_SCR_SH   = 4'd3;
	localparam logic [3:0] FUNC_CUR_SH   = 4'd4;
	localparam logic [3:0] FUNC_CLEAR    = 4'd5;
	localparam logic [3:0] FUNC_LINE     = 4'd6;
	localparam logic [3:0] FUNC_GOTO     = 4'd7;
	localparam logic [3:0] FUNC_BL_ON    = 4'd8;
	localparam logic [3:0] FUNC_BL_OFF   = 4'd9;
	localparam logic [3:0] FUNC_BL_TOG   = 4'd10;

	localparam logic [1:0] MODE_SHOW  = 2'd0;
	localparam logic [1:0] MODE_HIDE  = 2'd1;
	localparam logic [1:0] MODE_BLINK = 2'd2;
	localparam logic [1:0] MODE_FIXED = 2'd3;

	localparam logic [7:0] CHAR_NEWLINE = 8'd10;

	localparam logic [7:0] LCD_WAKE       = 8'h30;
	localparam logic [7:0] LCD_4BIT       = 8'h20;
	localparam logic [7:0] LCD_FUNC_SET   = 8'h28;
	localparam logic [7:0] LCD_DISP_ON    = 8'h0C;
	localparam logic [7:0] LCD_ENTRY      = 8'h06;
	localparam logic [7:0] LCD_CLEAR      = 8'h01;
	localparam logic [7:0] LCD_HOME       = 8'h02;
	localparam logic [7:0] LCD_LINE1      = 8'h80;
	localparam logic [7:0] LCD_LINE2      = 8'hC0;
	localparam logic [7:0] LCD_SCR_LEFT   = 8'h18;
	localparam logic [7:0] LCD_SCR_RIGHT  = 8'h1C;
	localparam logic [7:0] LCD_CUR_LEFT   = 8'h10;
	localparam logic [7:0] LCD_CUR_RIGHT  = 8'h14;

	localparam logic [7:0] ATTR_CURSOR = 8'h02;
	localparam logic [7:0] ATTR_BLINK  = 8'h01;

	localparam logic [7:0] GOTO_COLS = 8'd40;
	localparam logic [7:0] GOTO_ROWS = 8'd2;

	localparam logic [STEP_W-1:0] INIT_LEN = 6'd7;

	typedef struct packed {
		logic       rs;
		logic [7:0] code;
		logic       both;
		logic [4:0] wait_ms;
	} wr_t;

	typedef struct packed {
		logic start;
		logic load;
	} cmd_t;

	typedef struct packed {
		logic final_step;
	} status_t;

	function automatic wr_t init_entry(input logic [2:0] k);
		wr_t w;
		w.rs = 1'b0;
		unique case (k)
			3'd0: begin w.code = LCD_WAKE;     w.both = 1'b0; w.wait_ms = 5'd25; end
			3'd1: begin w.code = LCD_WAKE;     w.both = 1'b0; w.wait_ms = 5'd5;  end
			3'd2: begin w.code = LCD_WAKE;     w.both = 1'b0; w.wait_ms = 5'd2;  end
			3'd3: begin w.code = LCD_4BIT;     w.both = 1'b0; w.wait_ms = 5'd0;  end
			3'd4: begin w.code = LCD_FUNC_SET; w.both = 1'b1; w.wait_ms = 5'd0;  end
			3'd5: begin w.code = LCD_DISP_ON;  w.both = 1'b1; w.wait_ms = 5'd0;  end
			default: begin w.code = LCD_ENTRY; w.both = 1'b1; w.wait_ms = 5'd0;  end
		endcase
		return w;
	endfunction

endpackage

### design/lcdseq_ctrl.sv
module lcdseq_ctrl import lcdseq_pkg::*; (
	input  logic    clk,
	input  logic    arst_n,
	input  logic    in_valid,
	output logic    in_stall,
	output logic    out_valid,
	input  logic    out_stall,
	input  status_t status,
	output cmd_t    cmd
);

	localparam logic ST_IDLE = 1'b0;
	localparam logic ST_RUN  = 1'b1;

	logic state_q;
	logic out_valid_q;

	assign in_stall  = (state_q == ST_RUN);
	assign out_valid = out_valid_q;

	always_comb begin
		cmd.start = in_valid && (state_q == ST_IDLE);
		cmd.load  = (state_q == ST_RUN) && (!out_valid_q || !out_stall);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			out_valid_q <= 1'b0;
		end else begin
			unique case (state_q)
				ST_IDLE: begin
					if (cmd.start)
						state_q <= ST_RUN;
				end
				default: begin
					if (cmd.load && status.final_step)
						state_q <= ST_IDLE;
				end
			endcase
			if (cmd.load)
				out_valid_q <= 1'b1;
			else if (!out_stall)
				out_valid_q <= 1'b0;
		end
	end

endmodule

### design/lcdseq_dp.sv
module lcdseq_dp import lcdseq_pkg::*; #(
	parameter int MAX_SHIFT = 40
) (
	input  logic       clk,
	input  logic       arst_n,
	input  cmd_t       cmd,
	output status_t    status,
	input  logic [3:0] func,
	input  logic [7:0] char_code,
	input  logic [1:0] cursor_mode,
	input  logic       direction,
	input  logic [7:0] count,
	input  logic [7:0] line_sel,
	input  logic [7:0] column,
	input  logic [7:0] row,
	output logic       write_valid,
	output logic       reg_select,
	output logic [7:0] code,
	output logic       both_nibbles,
	output logic [4:0] wait_ms,
	output logic       backlight,
	output logic       rejected,
	output logic       last
);

	logic [7:0]        attr_q;
	logic              light_q;
	logic [3:0]        func_q;
	logic [7:0]        char_q;
	logic              dir_q;
	logic              line2_q;
	logic              row2_q;
	logic              nowrite_q;
	logic              rej_q;
	logic [STEP_W-1:0] step_q;
	logic [STEP_W-1:0] total_q;

	logic [STEP_W-1:0] shift_cnt;
	logic [STEP_W-1:0] goto_cnt;
	logic              goto_ok;
	logic              line_ok;
	logic [STEP_W-1:0] total_d;
	logic              nowrite_d;
	logic              rej_d;
	logic [7:0]        attr_d;
	logic              light_d;
	wr_t               wr;

	assign status.final_step = (step_q == total_q - 1'b1);

	assign shift_cnt = (count > 8'(MAX_SHIFT)) ? STEP_W'(MAX_SHIFT) : count[STEP_W-1:0];
	// goto cursor steps share the shift limit
	assign goto_cnt  = (column > 8'(MAX_SHIFT)) ? STEP_W'(MAX_SHIFT) : column[STEP_W-1:0];
	assign goto_ok   = (row < GOTO_ROWS) && (column < GOTO_COLS);
	assign line_ok   = (line_sel[7:1] == 7'd0);

	// result count and state updates for a new request
	always_comb begin
		total_d   = STEP_W'(1);
		nowrite_d = 1'b0;
		rej_d     = 1'b0;
		attr_d    = attr_q;
		light_d   = light_q;
		unique case (func)
			FUNC_INIT: begin
				total_d = INIT_LEN;
				attr_d  = LCD_DISP_ON;
			end
			FUNC_CHAR: ;
			FUNC_CURSOR: begin
				unique case (cursor_mode)
					MODE_SHOW:  attr_d = attr_q | ATTR_CURSOR;
					MODE_HIDE:  attr_d = attr_q & ~ATTR_CURSOR;
					MODE_BLINK: attr_d = attr_q | ATTR_BLINK;
					default:    attr_d = attr_q & ~ATTR_BLINK;
				endcase
			end
			FUNC_SCR_SH, FUNC_CUR_SH: begin
				if (shift_cnt == '0)
					nowrite_d = 1'b1;
				else
					total_d = shift_cnt;
			end
			FUNC_CLEAR: total_d = STEP_W'(2);
			FUNC_LINE: begin
				nowrite_d = !line_ok;
				rej_d     = !line_ok;
			end
			FUNC_GOTO: begin
				if (goto_ok) begin
					total_d = goto_cnt + STEP_W'(2);
				end else begin
					nowrite_d = 1'b1;
					rej_d     = 1'b1;
				end
			end
			FUNC_BL_ON: begin
				nowrite_d = 1'b1;
				light_d   = 1'b1;
			end
			FUNC_BL_OFF: begin
				nowrite_d = 1'b1;
				light_d   = 1'b0;
			end
			FUNC_BL_TOG: begin
				nowrite_d = 1'b1;
				light_d   = !light_q;
			end
			default: begin
				nowrite_d = 1'b1;
				rej_d     = 1'b1;
			end
		endcase
	end

	// write for the current step
	always_comb begin
		wr.rs      = 1'b0;
		wr.code    = 8'd0;
		wr.both    = 1'b1;
		wr.wait_ms = 5'd0;
		unique case (func_q)
			FUNC_INIT: wr = init_entry(step_q[2:0]);
			FUNC_CHAR: begin
				if (char_q == CHAR_NEWLINE) begin
					wr.code = LCD_LINE2;
				end else begin
					wr.rs   = 1'b1;
					wr.code = char_q;
				end
			end
			FUNC_CURSOR: wr.code = attr_q;
			FUNC_SCR_SH: wr.code = dir_q ? LCD_SCR_RIGHT : LCD_SCR_LEFT;
			FUNC_CUR_SH: wr.code = dir_q ? LCD_CUR_RIGHT : LCD_CUR_LEFT;
			FUNC_CLEAR:  wr.code = (step_q == '0) ? LCD_CLEAR : LCD_LINE1;
			FUNC_LINE:   wr.code = line2_q ? LCD_LINE2 : LCD_LINE1;
			FUNC_GOTO: begin
				if (step_q == '0) begin
					wr.code = LCD_HOME;
				end else if (step_q == STEP_W'(1)) begin
					wr.code    = row2_q ? LCD_LINE2 : LCD_LINE1;
					wr.wait_ms = 5'd2;
				end else begin
					wr.code = LCD_CUR_RIGHT;
				end
			end
			default: ;
		endcase
		if (nowrite_q) begin
			wr.rs      = 1'b0;
			wr.code    = 8'd0;
			wr.both    = 1'b0;
			wr.wait_ms = 5'd0;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			attr_q  <= LCD_DISP_ON;
			light_q <= 1'b0;
		end else if (cmd.start) begin
			attr_q  <= attr_d;
			light_q <= light_d;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.start) begin
			func_q    <= func;
			char_q    <= char_code;
			dir_q     <= direction;
			line2_q   <= line_sel[0];
			row2_q    <= row[0];
			nowrite_q <= nowrite_d;
			rej_q     <= rej_d;
			total_q   <= total_d;
			step_q    <= '0;
		end else if (cmd.load) begin
			step_q <= step_q + 1'b1;
		end
		if (cmd.load) begin
			write_valid  <= !nowrite_q;
			reg_select   <= wr.rs;
			code         <= wr.code;
			both_nibbles <= wr.both;
			wait_ms      <= wr.wait_ms;
			backlight    <= light_q;
			rejected     <= rej_q;
			last         <= status.final_step;
		end
	end

endmodule

### design/char_lcd_command_sequencer_core.sv
// channel   direction  handshake              payload
// request   in         in_valid / in_stall    func char_code cursor_mode direction count
//                                             line_sel column row
// write     out        out_valid / out_stall  write_valid reg_select code both_nibbles
//                                             wait_ms backlight rejected last
//
// a request is taken, then one write result per cycle is loaded into the output
// register unless the output stalls: 1 to 41 results (up to MAX_SHIFT for shifts)
// the step counter in the datapath sets the pace; in_stall is high while it runs
// output stalls hold the result register and pause the step counter
// arst_n clears the controller, the display attribute (0x0C) and the backlight
module char_lcd_command_sequencer_core import lcdseq_pkg::*; #(
	parameter int MAX_SHIFT = 40
) (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       in_valid,
	output logic       in_stall,
	input  logic [3:0] func,
	input  logic [7:0] char_code,
	input  logic [1:0] cursor_mode,
	input  logic       direction,
	input  logic [7:0] count,
	input  logic [7:0] line_sel,
	input  logic [7:0] column,
	input  logic [7:0] row,
	output logic       out_valid,
	input  logic       out_stall,
	output logic       write_valid,
	output logic       reg_select,
	output logic [7:0] code,
	output logic       both_nibbles,
	output logic [4:0] wait_ms,
	output logic       backlight,
	output logic       rejected,
	output logic       last
);

	cmd_t    cmd;
	status_t status;

	lcdseq_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_stall  (in_stall),
		.out_valid (out_valid),
		.out_stall (out_stall),
		.status    (status),
		.cmd       (cmd)
	);

	lcdseq_dp #(
		.MAX_SHIFT (MAX_SHIFT)
	) u_dp (
		.clk          (clk),
		.arst_n       (arst_n),
		.cmd          (cmd),
		.status       (status),
		.func         (func),
		.char_code    (char_code),
		.cursor_mode  (cursor_mode),
		.direction    (direction),
		.count        (count),
		.line_sel     (line_sel),
		.column       (column),
		.row          (row),
		.write_valid  (write_valid),
		.reg_select   (reg_select),
		.code         (code),
		.both_nibbles (both_nibbles),
		.wait_ms      (wait_ms),
		.backlight    (backlight),
		.rejected     (rejected),
		.last         (last)
	);

	// an accepted request keeps the input side busy while it expands
	a_busy_after_accept: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && !in_stall |=> in_stall)
		else $error("input not stalled after request transfer");

	// a rejected request gives one empty result
	a_reject_single: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && rejected |-> last && !write_valid)
		else $error("rejected request produced a write");

	a_empty_is_last: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !write_valid |-> last && (code == 8'd0) && (wait_ms == 5'd0))
		else $error("empty result not final or not cleared");

endmodule
